[design/ldedit_pkg.sv]
// Shared types, constants and codes for the line editor.
package ldedit_pkg;

   localparam int LINE_LENGTH = 32;
   localparam int LEN_W       = $clog2(LINE_LENGTH + 1);
   localparam int ADDR_W      = $clog2(LINE_LENGTH);
   localparam int CSR_IDX_W   = 3;

   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_LENGTH);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LFLAGS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ERASE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KILL    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WERASE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REPRINT = 3'd4;

   localparam logic [4:0] LFLAGS_RESET  = 5'd23;
   localparam logic [7:0] ERASE_RESET   = 8'd127;
   localparam logic [7:0] KILL_RESET    = 8'd21;
   localparam logic [7:0] WERASE_RESET  = 8'd23;
   localparam logic [7:0] REPRINT_RESET = 8'd18;

   // Local flag bits
   localparam int LF_CANON   = 0;
   localparam int LF_ECHO    = 1;
   localparam int LF_ECHOK   = 2;
   localparam int LF_ECHOPRT = 3;
   localparam int LF_ECHOKNL = 4;

   localparam logic [7:0] CH_ESC      = 8'h1b;
   localparam logic [7:0] CH_LBRACKET = 8'h5b;
   localparam logic [7:0] CH_LEFT     = 8'h44;
   localparam logic [7:0] CH_RIGHT    = 8'h43;
   localparam logic [7:0] CH_SEMI     = 8'h3b;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_DISABLED = 8'hff;
   localparam logic [7:0] CH_PRINT_LO = 8'h20;
   localparam logic [7:0] CH_PRINT_HI = 8'h7e;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;

   typedef enum logic [2:0] {
      ACT_NONE  = 3'd0,
      ACT_ECHO  = 3'd1,
      ACT_BS    = 3'd2,
      ACT_LEFT  = 3'd3,
      ACT_RIGHT = 3'd4,
      ACT_INS   = 3'd5,
      ACT_DEL   = 3'd6,
      ACT_NL    = 3'd7
   } act_type;

   typedef enum logic [1:0] {
      PM_NORMAL = 2'd0,
      PM_ESC    = 2'd1,
      PM_PARAM  = 2'd2
   } pm_type;

   typedef enum logic [2:0] {
      CLS_ERASE,
      CLS_KILL,
      CLS_WORD,
      CLS_REPRINT,
      CLS_PARSE
   } cls_type;

   typedef enum logic [1:0] {
      RET_DONE,
      RET_KILL,
      RET_WORD
   } ret_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_REJECT,
      S_UNPUT,
      S_UL_RD,
      S_UL_WR,
      S_UNPUT_MA,
      S_UNPUT_MB,
      S_UNPUT_END,
      S_KILL_CHK,
      S_KILL_ECHO,
      S_KILL_NL,
      S_WE_CHK,
      S_WE_TEST,
      S_INS,
      S_IR_RD,
      S_IR_WR,
      S_INS_E,
      S_INS_PUT,
      S_INS_ECHO,
      S_MOVE,
      S_FINISH
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_DECODE,
      OP_UL_INIT,
      OP_RD_IDX,
      OP_UL_WR,
      OP_MID_A,
      OP_UNPUT_END,
      OP_KILL_CLEAR,
      OP_WE_RD,
      OP_WE_NEXT,
      OP_IR_INIT,
      OP_IR_RD,
      OP_IR_WR,
      OP_INS_PUT,
      OP_MOVE
   } op_type;

   typedef struct packed {
      op_type  op;
      logic    emit;
      act_type act;
      logic    rej;
      logic    finish;
   } cmd_type;

   typedef struct packed {
      logic    full;
      cls_type cls;
      logic    kill_erase;
      logic    kill_nl;
      logic    echo_on;
      logic    parse_ins;
      logic    parse_move;
      logic    move_back;
      logic    cur_nz;
      logic    cur_lt_len;
      logic    cur_le_len;
      logic    ul_more;
      logic    ir_more;
      logic    we_cond;
      logic    we_blank;
      logic    we_phase;
      logic    move_more;
      logic    emit_ok;
      logic    pend_valid;
   } status_type;

endpackage

[design/ldedit_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ldedit_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/ldedit_dp.sv]
// Datapath: registers, line store, escape parser and result staging.
module ldedit_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [7:0]                       req_char_in,
   input  logic                             csr_we,
   input  logic [ldedit_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                       csr_wdata,
   input  ldedit_pkg::cmd_type              cmd,
   output ldedit_pkg::status_type           status,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [2:0]                       rsp_action,
   output logic [7:0]                       rsp_byte_out,
   output logic                             rsp_last,
   output logic                             rsp_accepted
);
   import ldedit_pkg::*;

   logic [7:0]       char_ff, char_in;
   logic [4:0]       lflags_ff, lflags_in;
   logic [7:0]       erase_ff, erase_in, kill_ff, kill_in;
   logic [7:0]       werase_ff, werase_in, reprint_ff, reprint_in;
   logic [LEN_W-1:0] cursor_ff, cursor_in, len_ff, len_in, idx_ff, idx_in;
   pm_type           pm_ff, pm_in;
   logic [7:0]       fp_ff, fp_in;
   logic [1:0]       pc_ff, pc_in;
   logic [7:0]       move_cnt_ff, move_cnt_in;
   logic             move_back_ff, move_back_in;
   logic             we_end_ff, we_end_in, we_phase_ff, we_phase_in;
   logic             pend_valid_ff, pend_valid_in;
   act_type          pend_act_ff, pend_act_in;
   logic [7:0]       pend_byte_ff, pend_byte_in;
   logic             pend_acc_ff, pend_acc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   act_type          rsp_act_ff, rsp_act_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_last_ff, rsp_last_in, rsp_acc_ff, rsp_acc_in;

   logic             fire, emit_ok, slot_free, full, canon;
   cls_type          cls;
   logic             is_digit, parse_ins, parse_move;
   logic [11:0]      fp_prod;
   logic             rd_en, wr_en;
   logic [LEN_W-1:0] rd_idx, wr_idx;
   logic [7:0]       wr_data, rd_data;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign emit_ok   = !pend_valid_ff || slot_free;
   assign fire      = !(cmd.emit || cmd.finish) || emit_ok;
   assign full      = (len_ff == LEN_MAX);
   assign canon     = lflags_ff[LF_CANON];

   always_comb begin
      if (canon && erase_ff != CH_DISABLED && erase_ff == char_ff) begin
         cls = CLS_ERASE;
      end else if (canon && kill_ff != CH_DISABLED && kill_ff == char_ff) begin
         cls = CLS_KILL;
      end else if (canon && werase_ff != CH_DISABLED && werase_ff == char_ff) begin
         cls = CLS_WORD;
      end else if (canon && reprint_ff != CH_DISABLED && reprint_ff == char_ff) begin
         cls = CLS_REPRINT;
      end else begin
         cls = CLS_PARSE;
      end
   end

   assign is_digit  = (char_ff >= CH_ZERO) && (char_ff <= CH_NINE);
   assign parse_ins = (pm_ff == PM_NORMAL) && (char_ff >= CH_PRINT_LO) &&
                      (char_ff <= CH_PRINT_HI);
   assign parse_move = (pm_ff == PM_PARAM) && (pc_ff < 2'd2) && !is_digit &&
                       (char_ff != CH_SEMI) && (char_ff == CH_LEFT || char_ff == CH_RIGHT);
   // first_param * 10 + digit, saturated later
   assign fp_prod = ({4'd0, fp_ff} << 3) + ({4'd0, fp_ff} << 1) +
                    {4'd0, char_ff - CH_ZERO};

   always_comb begin
      char_in      = char_ff;
      lflags_in    = lflags_ff;
      erase_in     = erase_ff;
      kill_in      = kill_ff;
      werase_in    = werase_ff;
      reprint_in   = reprint_ff;
      cursor_in    = cursor_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      pm_in        = pm_ff;
      fp_in        = fp_ff;
      pc_in        = pc_ff;
      move_cnt_in  = move_cnt_ff;
      move_back_in = move_back_ff;
      we_end_in    = we_end_ff;
      we_phase_in  = we_phase_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_LFLAGS:  lflags_in  = csr_wdata[4:0];
            CSR_ERASE:   erase_in   = csr_wdata;
            CSR_KILL:    kill_in    = csr_wdata;
            CSR_WERASE:  werase_in  = csr_wdata;
            CSR_REPRINT: reprint_in = csr_wdata;
            default: ;
         endcase
      end

      if (fire) begin
         case (cmd.op)
            OP_LOAD: char_in = req_char_in;
            OP_DECODE: begin
               move_cnt_in  = fp_ff;
               move_back_in = (char_ff == CH_LEFT);
               we_end_in    = (cursor_ff == len_ff);
               we_phase_in  = 1'b0;
               if (!full && cls == CLS_PARSE) begin
                  case (pm_ff)
                     PM_NORMAL: begin
                        if (char_ff == CH_ESC) begin
                           pm_in = PM_ESC;
                        end
                     end
                     PM_ESC: begin
                        if (char_ff == CH_LBRACKET) begin
                           pm_in = PM_PARAM;
                           pc_in = 2'd0;
                           fp_in = 8'd0;
                        end else begin
                           pm_in = PM_NORMAL;
                        end
                     end
                     PM_PARAM: begin
                        if (pc_ff < 2'd2 && is_digit) begin
                           if (pc_ff == 2'd0) begin
                              fp_in = (fp_prod > 12'd255) ? 8'hff : fp_prod[7:0];
                           end
                        end else if (pc_ff < 2'd2 && char_ff == CH_SEMI) begin
                           pc_in = pc_ff + 2'd1;
                        end else if (pc_ff >= 2'd2) begin
                           pm_in = PM_NORMAL;
                        end else begin
                           pc_in = pc_ff + 2'd1;
                           pm_in = PM_NORMAL;
                        end
                     end
                     default: pm_in = PM_NORMAL;
                  endcase
               end
            end
            OP_UL_INIT: idx_in = cursor_ff;
            OP_UL_WR:   idx_in = idx_ff + 1'b1;
            OP_MID_A: begin
               len_in    = len_ff - 1'b1;
               cursor_in = cursor_ff - 1'b1;
            end
            OP_UNPUT_END: begin
               len_in    = len_ff - 1'b1;
               cursor_in = len_ff - 1'b1;
            end
            OP_KILL_CLEAR: begin
               len_in    = '0;
               cursor_in = '0;
            end
            OP_WE_NEXT: we_phase_in = 1'b1;
            OP_IR_INIT: idx_in = len_ff;
            OP_IR_WR:   idx_in = idx_ff - 1'b1;
            OP_INS_PUT: begin
               len_in    = len_ff + 1'b1;
               cursor_in = cursor_ff + 1'b1;
            end
            OP_MOVE: begin
               cursor_in   = move_back_ff ? cursor_ff - 1'b1 : cursor_ff + 1'b1;
               move_cnt_in = move_cnt_ff - 8'd1;
            end
            default: ;
         endcase
      end
   end

   // Hold one result back so the final one can carry the last flag.
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_act_in   = pend_act_ff;
      pend_byte_in  = pend_byte_ff;
      pend_acc_in   = pend_acc_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_act_in    = rsp_act_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_acc_in    = rsp_acc_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fire && (cmd.emit || cmd.finish) && pend_valid_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_act_in    = pend_act_ff;
         rsp_byte_in   = pend_byte_ff;
         rsp_acc_in    = pend_acc_ff;
         rsp_last_in   = cmd.finish;
         pend_valid_in = 1'b0;
      end
      if (fire && cmd.emit) begin
         pend_valid_in = 1'b1;
         pend_act_in   = cmd.act;
         pend_byte_in  = (cmd.act == ACT_ECHO) ? char_ff : 8'd0;
         pend_acc_in   = !cmd.rej;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lflags_ff     <= LFLAGS_RESET;
         erase_ff      <= ERASE_RESET;
         kill_ff       <= KILL_RESET;
         werase_ff     <= WERASE_RESET;
         reprint_ff    <= REPRINT_RESET;
         cursor_ff     <= '0;
         len_ff        <= '0;
         pm_ff         <= PM_NORMAL;
         fp_ff         <= 8'd0;
         pc_ff         <= 2'd0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         lflags_ff     <= lflags_in;
         erase_ff      <= erase_in;
         kill_ff       <= kill_in;
         werase_ff     <= werase_in;
         reprint_ff    <= reprint_in;
         cursor_ff     <= cursor_in;
         len_ff        <= len_in;
         pm_ff         <= pm_in;
         fp_ff         <= fp_in;
         pc_ff         <= pc_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      char_ff      <= char_in;
      idx_ff       <= idx_in;
      move_cnt_ff  <= move_cnt_in;
      move_back_ff <= move_back_in;
      we_end_ff    <= we_end_in;
      we_phase_ff  <= we_phase_in;
      pend_act_ff  <= pend_act_in;
      pend_byte_ff <= pend_byte_in;
      pend_acc_ff  <= pend_acc_in;
      rsp_act_ff   <= rsp_act_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_acc_ff   <= rsp_acc_in;
   end

   // Line store access
   always_comb begin
      rd_en   = 1'b0;
      rd_idx  = idx_ff;
      wr_en   = 1'b0;
      wr_idx  = idx_ff;
      wr_data = rd_data;
      case (cmd.op)
         OP_RD_IDX: rd_en = 1'b1;
         OP_IR_RD: begin
            rd_en  = 1'b1;
            rd_idx = idx_ff - 1'b1;
         end
         OP_WE_RD: begin
            rd_en  = 1'b1;
            rd_idx = we_end_ff ? len_ff - 1'b1 : cursor_ff - 1'b1;
         end
         OP_UL_WR: begin
            wr_en  = 1'b1;
            wr_idx = idx_ff - 1'b1;
         end
         OP_IR_WR: wr_en = 1'b1;
         OP_INS_PUT: begin
            wr_en   = 1'b1;
            wr_idx  = cursor_ff;
            wr_data = char_ff;
         end
         default: ;
      endcase
   end

   ldedit_ram #(
      .WIDTH(8),
      .DEPTH(LINE_LENGTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_idx[ADDR_W-1:0]),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_idx[ADDR_W-1:0]),
      .rd_data(rd_data)
   );

   always_comb begin
      status.full       = full;
      status.cls        = cls;
      status.kill_erase = lflags_ff[LF_ECHOK] && !lflags_ff[LF_ECHOPRT];
      status.kill_nl    = lflags_ff[LF_ECHOKNL];
      status.echo_on    = lflags_ff[LF_ECHO];
      status.parse_ins  = parse_ins;
      status.parse_move = parse_move;
      status.move_back  = move_back_ff;
      status.cur_nz     = (cursor_ff != '0);
      status.cur_lt_len = (cursor_ff < len_ff);
      status.cur_le_len = (cursor_ff <= len_ff);
      status.ul_more    = (idx_ff < len_ff);
      status.ir_more    = (idx_ff > cursor_ff);
      status.we_cond    = we_end_ff ? (len_ff != '0) : (cursor_ff != '0);
      status.we_blank   = (rd_data == CH_SPACE) || (rd_data == CH_TAB);
      status.we_phase   = we_phase_ff;
      status.move_more  = (move_cnt_ff != 8'd0) &&
                          (move_back_ff ? (cursor_ff != '0) : (cursor_ff < len_ff));
      status.emit_ok    = emit_ok;
      status.pend_valid = pend_valid_ff;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_action   = rsp_act_ff;
   assign rsp_byte_out = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_accepted = rsp_acc_ff;

endmodule

[design/ldedit_ctrl.sv]
// Controller: sequences decode, shifts, erase loops and result emission.
module ldedit_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ldedit_pkg::status_type status,
   output ldedit_pkg::cmd_type    cmd
);
   import ldedit_pkg::*;

   state_type state_ff, state_in;
   ret_type   ret_ff, ret_in;
   state_type ret_state;

   always_comb begin
      case (ret_ff)
         RET_KILL: ret_state = S_KILL_CHK;
         RET_WORD: ret_state = S_WE_CHK;
         default:  ret_state = S_FINISH;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (status.full) begin
               state_in = S_REJECT;
            end else begin
               case (status.cls)
                  CLS_ERASE: begin
                     ret_in   = RET_DONE;
                     state_in = status.cur_nz ? S_UNPUT : S_FINISH;
                  end
                  CLS_KILL: state_in = status.kill_erase ? S_KILL_CHK : S_KILL_ECHO;
                  CLS_WORD: state_in = S_WE_CHK;
                  CLS_PARSE: begin
                     if (status.parse_ins) begin
                        state_in = S_INS;
                     end else if (status.parse_move) begin
                        state_in = S_MOVE;
                     end else begin
                        state_in = S_FINISH;
                     end
                  end
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_REJECT:    if (status.emit_ok) state_in = S_FINISH;
         S_UNPUT: begin
            if (status.cur_nz && status.cur_lt_len) begin
               state_in = S_UL_RD;
            end else if (status.cur_nz) begin
               state_in = S_UNPUT_END;
            end else begin
               state_in = ret_state;
            end
         end
         S_UL_RD:     state_in = status.ul_more ? S_UL_WR : S_UNPUT_MA;
         S_UL_WR:     state_in = S_UL_RD;
         S_UNPUT_MA:  if (status.emit_ok) state_in = S_UNPUT_MB;
         S_UNPUT_MB:  if (status.emit_ok) state_in = ret_state;
         S_UNPUT_END: if (status.emit_ok) state_in = ret_state;
         S_KILL_CHK: begin
            ret_in   = RET_KILL;
            state_in = status.cur_nz ? S_UNPUT : S_FINISH;
         end
         S_KILL_ECHO: begin
            if (status.emit_ok) begin
               state_in = status.kill_nl ? S_KILL_NL : S_FINISH;
            end
         end
         S_KILL_NL:   if (status.emit_ok) state_in = S_FINISH;
         S_WE_CHK:    state_in = status.we_cond ? S_WE_TEST : S_FINISH;
         S_WE_TEST: begin
            ret_in = RET_WORD;
            // blank phase falls through to the word phase on the same byte
            if (!status.we_phase || !status.we_blank) begin
               state_in = S_UNPUT;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_INS:       state_in = status.cur_lt_len ? S_IR_RD : S_INS_PUT;
         S_IR_RD:     state_in = status.ir_more ? S_IR_WR : S_INS_E;
         S_IR_WR:     state_in = S_IR_RD;
         S_INS_E:     if (status.emit_ok) state_in = S_INS_PUT;
         S_INS_PUT:   state_in = status.echo_on ? S_INS_ECHO : S_FINISH;
         S_INS_ECHO:  if (status.emit_ok) state_in = S_FINISH;
         S_MOVE: begin
            if (!status.move_more) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH:    if (status.emit_ok) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd.op     = OP_NONE;
      cmd.emit   = 1'b0;
      cmd.act    = ACT_NONE;
      cmd.rej    = 1'b0;
      cmd.finish = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = OP_LOAD;
            end
         end
         S_DECODE: cmd.op = OP_DECODE;
         S_REJECT: begin
            cmd.emit = 1'b1;
            cmd.rej  = 1'b1;
         end
         S_UNPUT: begin
            if (status.cur_nz && status.cur_lt_len) begin
               cmd.op = OP_UL_INIT;
            end
         end
         S_UL_RD: begin
            if (status.ul_more) begin
               cmd.op = OP_RD_IDX;
            end
         end
         S_UL_WR: cmd.op = OP_UL_WR;
         S_UNPUT_MA: begin
            cmd.op   = OP_MID_A;
            cmd.emit = 1'b1;
            cmd.act  = ACT_LEFT;
         end
         S_UNPUT_MB: begin
            cmd.emit = 1'b1;
            cmd.act  = ACT_DEL;
         end
         S_UNPUT_END: begin
            cmd.op   = OP_UNPUT_END;
            cmd.emit = 1'b1;
            cmd.act  = ACT_BS;
         end
         S_KILL_ECHO: begin
            cmd.op   = OP_KILL_CLEAR;
            cmd.emit = 1'b1;
            cmd.act  = ACT_ECHO;
         end
         S_KILL_NL: begin
            cmd.emit = 1'b1;
            cmd.act  = ACT_NL;
         end
         S_WE_CHK: begin
            if (status.we_cond) begin
               cmd.op = OP_WE_RD;
            end
         end
         S_WE_TEST: begin
            if (!status.we_phase && !status.we_blank) begin
               cmd.op = OP_WE_NEXT;
            end
         end
         S_INS: begin
            if (status.cur_lt_len) begin
               cmd.op = OP_IR_INIT;
            end
         end
         S_IR_RD: begin
            if (status.ir_more) begin
               cmd.op = OP_IR_RD;
            end
         end
         S_IR_WR: cmd.op = OP_IR_WR;
         S_INS_E: begin
            cmd.emit = 1'b1;
            cmd.act  = ACT_INS;
         end
         S_INS_PUT: cmd.op = OP_INS_PUT;
         S_INS_ECHO: begin
            cmd.emit = 1'b1;
            cmd.act  = ACT_ECHO;
         end
         S_MOVE: begin
            if (status.move_more) begin
               cmd.op   = OP_MOVE;
               cmd.emit = 1'b1;
               cmd.act  = status.move_back ? ACT_LEFT : ACT_RIGHT;
            end
         end
         S_FINISH: cmd.finish = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= RET_DONE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

endmodule

[design/line_discipline_editor.sv]
// Top level of the canonical line editor: controller, datapath and checks.
//
// Each byte is handled one at a time: req_ready is high only while no byte is
// in work. Inserting, erasing or deleting in mid-line walks the line store one
// entry at a time through its single read and write port, so the work for such
// a byte grows with line_len - cursor_pos. A word erase or a kill in mid-line
// repeats that walk for each erased character. Cursor moves emit one result a
// cycle while the result side is not stalled.
// Results leave through a one-item holding stage and an output register, one
// per cycle while rsp_ready stays high; a stalled consumer stalls the work.
module line_discipline_editor (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_char_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [2:0]                       rsp_action,
   output logic [7:0]                       rsp_byte_out,
   output logic                             rsp_last,
   output logic                             rsp_accepted,
   input  logic                             csr_we,
   input  logic [ldedit_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                       csr_wdata
);
   import ldedit_pkg::*;

   cmd_type    cmd;
   status_type status;

   ldedit_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   ldedit_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_char_in (req_char_in),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .status      (status),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_action  (rsp_action),
      .rsp_byte_out(rsp_byte_out),
      .rsp_last    (rsp_last),
      .rsp_accepted(rsp_accepted)
   );

`ifndef SYNTHESIS
   a_cursor_in_line: assert property (@(posedge clock) disable iff (reset)
      status.cur_le_len)
      else $error("cursor beyond line length");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !status.pend_valid)
      else $error("result still held while idle");

   a_finish_drains: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && status.emit_ok) |=> (!status.pend_valid && req_ready))
      else $error("finish did not drain held result");
`endif

endmodule

[tb/ldedit_checker.sv]
// Checker for the line editor: mirrors the line state, predicts and compares results.
`timescale 1ns / 1ps
module ldedit_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [7:0]                       req_char_in,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [2:0]                       rsp_action,
   input  logic [7:0]                       rsp_byte_out,
   input  logic                             rsp_last,
   input  logic                             rsp_accepted,
   input  logic                             csr_we,
   input  logic [ldedit_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                       csr_wdata,
   output int                               fail_count,
   output int                               pending
);
   import ldedit_pkg::*;

   typedef struct packed {
      act_type    act;
      logic [7:0] b;
      logic       last;
      logic       acc;
   } edit_result_type;

   edit_result_type want_q[$];

   logic [4:0] m_flags;
   logic [7:0] m_erase, m_kill, m_werase, m_reprint;
   logic [7:0] m_line [LINE_LENGTH];
   int m_cur, m_len, m_nout;
   pm_type m_pm;
   int m_param, m_pcnt;

   assign pending = want_q.size();

   function automatic bit is_blank(logic [7:0] b);
      return b == CH_SPACE || b == CH_TAB;
   endfunction

   function automatic bit hits(logic [7:0] r, logic [7:0] c);
      return r != CH_DISABLED && r == c;
   endfunction

   task automatic push_act(act_type a, logic [7:0] b);
      edit_result_type r;
      if (m_nout >= 64) return;
      r.act  = a;
      r.b    = (a == ACT_ECHO) ? b : 8'd0;
      r.last = 1'b0;
      r.acc  = 1'b1;
      want_q.push_back(r);
      m_nout++;
   endtask

   task automatic erase_left();
      if (m_cur > 0 && m_cur < m_len) begin
         for (int i = m_cur; i < m_len; i++) begin
            m_line[i-1] = m_line[i];
            m_line[i]   = 8'd0;
         end
         m_len--;
         push_act(ACT_LEFT, 0);
         m_cur--;
         push_act(ACT_DEL, 0);
      end else if (m_cur > 0 && m_len > 0) begin
         m_line[m_len-1] = 8'd0;
         m_cur = m_len - 1;
         m_len--;
         push_act(ACT_BS, 0);
      end
   endtask

   task automatic insert_char(logic [7:0] c);
      if (m_len >= LINE_LENGTH || m_cur > m_len) return;
      if (m_cur < m_len) begin
         for (int i = m_len; i > m_cur; i--) begin
            m_line[i]   = m_line[i-1];
            m_line[i-1] = 8'd0;
         end
         push_act(ACT_INS, 0);
      end
      m_len++;
      m_line[m_cur] = c;
      m_cur++;
      if (m_flags[LF_ECHO]) push_act(ACT_ECHO, c);
   endtask

   task automatic erase_word();
      if (m_cur == m_len) begin
         while (m_len > 0 && is_blank(m_line[m_len-1])) erase_left();
         while (m_len > 0 && !is_blank(m_line[m_len-1])) erase_left();
      end else begin
         while (m_cur > 0 && is_blank(m_line[m_cur-1])) erase_left();
         while (m_cur > 0 && !is_blank(m_line[m_cur-1])) erase_left();
      end
   endtask

   task automatic parse_char(logic [7:0] c);
      case (m_pm)
         PM_NORMAL: begin
            if (c == CH_ESC) m_pm = PM_ESC;
            else if (c >= CH_PRINT_LO && c <= CH_PRINT_HI) insert_char(c);
         end
         PM_ESC: begin
            if (c == CH_LBRACKET) begin
               m_pm = PM_PARAM;
               m_pcnt = 0;
               m_param = 0;
            end else m_pm = PM_NORMAL;
         end
         default: begin
            if (m_pcnt < 2 && c >= CH_ZERO && c <= CH_NINE) begin
               if (m_pcnt == 0) begin
                  m_param = m_param * 10 + (c - CH_ZERO);
                  if (m_param > 255) m_param = 255;
               end
            end else if (m_pcnt < 2 && c == CH_SEMI) begin
               m_pcnt++;
            end else if (m_pcnt >= 2) begin
               m_pm = PM_NORMAL;
            end else begin
               int n;
               n = m_param;
               m_pcnt++;
               if (c == CH_LEFT) begin
                  while (n > 0 && m_cur > 0) begin
                     push_act(ACT_LEFT, 0);
                     m_cur--;
                     n--;
                  end
               end else if (c == CH_RIGHT) begin
                  while (n > 0 && m_cur < m_len) begin
                     push_act(ACT_RIGHT, 0);
                     m_cur++;
                     n--;
                  end
               end
               m_pm = PM_NORMAL;
            end
         end
      endcase
   endtask

   task automatic predict_char(logic [7:0] c);
      edit_result_type r;
      m_nout = 0;
      if (m_len >= LINE_LENGTH) begin
         r.act = ACT_NONE; r.b = 0; r.last = 1'b1; r.acc = 1'b0;
         want_q.push_back(r);
         return;
      end
      if (m_flags[LF_CANON] && hits(m_erase, c)) begin
         if (m_len > 0) erase_left();
      end else if (m_flags[LF_CANON] && hits(m_kill, c)) begin
         if (m_flags[LF_ECHOK] && !m_flags[LF_ECHOPRT]) begin
            while (m_cur > 0 && m_nout < 64) erase_left();
         end else begin
            push_act(ACT_ECHO, c);
            if (m_flags[LF_ECHOKNL]) push_act(ACT_NL, 0);
            foreach (m_line[i]) m_line[i] = 8'd0;
            m_cur = 0;
            m_len = 0;
         end
      end else if (m_flags[LF_CANON] && hits(m_werase, c)) begin
         erase_word();
      end else if (!(m_flags[LF_CANON] && hits(m_reprint, c))) begin
         parse_char(c);
      end
      if (m_nout > 0) want_q[want_q.size()-1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         m_flags = LFLAGS_RESET; m_erase = ERASE_RESET; m_kill = KILL_RESET;
         m_werase = WERASE_RESET; m_reprint = REPRINT_RESET;
         foreach (m_line[i]) m_line[i] = 8'd0;
         m_cur = 0; m_len = 0; m_pm = PM_NORMAL; m_param = 0; m_pcnt = 0;
         want_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_LFLAGS:  m_flags   = csr_wdata[4:0];
               CSR_ERASE:   m_erase   = csr_wdata;
               CSR_KILL:    m_kill    = csr_wdata;
               CSR_WERASE:  m_werase  = csr_wdata;
               CSR_REPRINT: m_reprint = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_char(req_char_in);
         if (rsp_valid && rsp_ready) begin
            if (want_q.size() == 0) begin
               $display("%0t: unexpected item act=%0d byte=%02h last=%0b acc=%0b",
                        $time, rsp_action, rsp_byte_out, rsp_last, rsp_accepted);
               fail_count <= fail_count + 1;
            end else begin
               edit_result_type w;
               w = want_q.pop_front();
               if (rsp_action !== w.act || rsp_byte_out !== w.b ||
                   rsp_last !== w.last || rsp_accepted !== w.acc) begin
                  $display("%0t: mismatch expected act=%0d byte=%02h last=%0b acc=%0b",
                           $time, w.act, w.b, w.last, w.acc);
                  $display("%0t:          actual   act=%0d byte=%02h last=%0b acc=%0b",
                           $time, rsp_action, rsp_byte_out, rsp_last, rsp_accepted);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

[tb/tb_top.sv]
// Testbench top for the line editor: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module tb_top;
   import ldedit_pkg::*;

   // Index past the last register; writes to it are ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_ready;
   logic [7:0] req_char_in = 8'd0;
   logic rsp_valid, rsp_ready = 1'b0;
   logic [2:0] rsp_action;
   logic [7:0] rsp_byte_out;
   logic rsp_last, rsp_accepted;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0] csr_wdata = 8'd0;
   int fail_count, pending;
   bit calm = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   line_discipline_editor dut (.*);
   ldedit_checker chk (.*);

   // Random stalls on the result side.
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            n = $urandom_range(1, 13);
            repeat (n) @(negedge clock);
            rsp_ready <= 1'b1;
         end else rsp_ready <= 1'b1;
      end
   end

   // Hold valid from one item to the next; drop it only for an idle burst.
   task automatic send_char(logic [7:0] c);
      int n;
      if (!calm && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= c;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [7:0] d);
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= d;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Let the block drain, then give it time to finish any silent work.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (2200) @(negedge clock);
   endtask

   task automatic send_seq(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d);
      send_char(a); send_char(b); send_char(c); send_char(d);
   endtask

   function automatic logic [7:0] pick_char(logic [7:0] er, logic [7:0] kl, logic [7:0] we);
      case ($urandom_range(0, 19))
         0:       return er;
         1:       return kl;
         2, 3:    return we;
         4, 5:    return ($urandom_range(0, 1)) ? CH_SPACE : CH_TAB;
         6:       return 8'($urandom_range(0, 255));
         7:       return REPRINT_RESET;
         default: return 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
      endcase
   endfunction

   task automatic random_phase(int count, logic [7:0] er, logic [7:0] kl, logic [7:0] we);
      int k;
      int since;
      k = 0;
      since = 0;
      while (k < count) begin
         if (kl != CH_DISABLED && since >= 20) begin
            // clear the line now and then so it rarely fills up
            send_char(kl);
            since = 0;
            k++;
         end else if ($urandom_range(0, 5) == 0) begin
            // cursor move, sometimes with a big or second parameter
            send_char(CH_ESC);
            send_char(CH_LBRACKET);
            case ($urandom_range(0, 4))
               0: ;
               1: send_char(8'h30 + 8'($urandom_range(0, 9)));
               2: begin send_char(8'h39); send_char(8'h39); send_char(8'h39); end
               3: begin send_char(8'h32); send_char(CH_SEMI); send_char(8'h35); end
               default: send_char(8'h31 + 8'($urandom_range(0, 3)));
            endcase
            send_char(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
                      ($urandom_range(0, 1) ? CH_LEFT : CH_RIGHT));
            k += 4;
            since += 4;
         end else begin
            send_char(pick_char(er, kl, we));
            k++;
            since++;
         end
      end
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: defaults, typing, moves, edits.
      send_seq("a", "b", " ", "c");
      send_seq(CH_ESC, CH_LBRACKET, "2", CH_LEFT);
      send_char("X");
      send_char(ERASE_RESET);
      send_char(WERASE_RESET);
      send_seq(CH_ESC, CH_LBRACKET, "9", CH_RIGHT);
      send_seq(CH_ESC, CH_LBRACKET, CH_LEFT, 8'h7e);
      send_char(REPRINT_RESET);
      send_char(KILL_RESET);
      send_seq(CH_ESC, "x", 8'h00, 8'hff);
      settle();

      // Default registers: kill erases one character at a time.
      random_phase(110, ERASE_RESET, KILL_RESET, WERASE_RESET);
      settle();

      // Echo-print set: kill echoes, adds a newline and clears the line.
      write_reg(CSR_LFLAGS, 8'd31);
      write_reg(CSR_ERASE, 8'd8);
      write_reg(CSR_KILL, 8'h0b);
      write_reg(CSR_WERASE, 8'd0);
      write_reg(CSR_REPRINT, CH_DISABLED);
      random_phase(100, 8'd8, 8'h0b, 8'd0);
      settle();

      // No idling from here on; echo off, kill disabled.
      calm = 1'b1;
      write_reg(CSR_LFLAGS, 8'd5);
      write_reg(CSR_KILL, CH_DISABLED);
      random_phase(40, 8'd8, CH_DISABLED, 8'd0);
      settle();

      // Non-canonical: fill the line, after which every byte is rejected.
      write_reg(CSR_LFLAGS, 8'd0);
      write_reg(CSR_UNUSED, 8'd0);
      for (int i = 0; i < 34; i++) send_char(8'h20 + 8'(i));
      send_char(KILL_RESET);
      settle();

      if (fail_count == 0 && pending == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
